>>> rtl/pla_pkg.sv
package pla_pkg;

  // Fixed-point format and exponent range.
  localparam int FRAC_BITS = 16;
  localparam int EXP_BITS  = 10;

  // Width of the shared multiplier operands and product.
  localparam int MW = 34;
  localparam int PW = 2 * MW;

  // Unit vector component, signed, magnitude up to one.
  localparam int UW = FRAC_BITS + 2;
  // Dot product accumulator, signed.
  localparam int AW = 2 * FRAC_BITS + 7;
  // Reflected vector component, signed.
  localparam int RW = FRAC_BITS + 5;
  // Unshadowed contribution of one light, unsigned.
  localparam int CTW = 33;
  // Iteration counter for the root and the divider.
  localparam int CNT_W = 6;

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [EXP_BITS-1:0] EXP_MAX = '1;
  localparam logic [16:0] CLARITY_ONE = 17'h10000;

  typedef enum logic [1:0] {
    MODE_HIT    = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_VIEW   = 2'd2,
    MODE_LIGHT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_AMBIENT     = 2'd0,
    KIND_POINT       = 2'd1,
    KIND_DIRECTIONAL = 2'd2,
    KIND_UNUSED      = 2'd3
  } kind_t;

endpackage

>>> rtl/phong_light_accumulator_unit.sv
// Phong light accumulator. Set-up transfers (mode 0, 1, 2) load the hit point, the surface
// normal and the view vector with the specular exponent; the normal and the view are reduced
// to unit length when they are loaded. Each light transfer (mode 3) adds the ambient level,
// or the diffuse and specular terms of a point or directional light scaled by the occluder's
// clarity when shadowed, or nothing for the unused kind, into a saturating Q16.16 sum, which
// is offered on the output when last_light is set and then cleared. All arithmetic runs on
// one shared signed 34 by 34 bit multiplier, a one-bit-per-cycle square root and a
// one-bit-per-cycle divider under a small sequencer, and in_ready is high only while the
// sequencer is idle; a hit point load leaves it idle. A normal or view transfer takes the
// magnitudes, the normalizing shift, the sum of squares, the root, three divisions of
// FRAC_BITS + 1 steps and the store of the result, or for a zero vector only the first and
// the last. A point or directional light is normalized likewise, then takes the diffuse
// term, the reflection, the specular dot product, the specular power by squaring per
// exponent bit and the shadow scaling; an ambient light goes straight to the sum. A finished
// sum waits in the output register while the next transfers are taken; only the next last
// light stalls until it has been collected.
module phong_light_accumulator_unit
  import pla_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic signed [31:0]          vec_x,
  input  logic signed [31:0]          vec_y,
  input  logic signed [31:0]          vec_z,
  input  logic [31:0]                 scalar,
  input  logic [1:0]                  light_kind,
  input  logic                        in_shadow,
  input  logic [16:0]                 occluder_clarity,
  input  logic                        last_light,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 total_intensity
);

  typedef enum logic [4:0] {
    S_IDLE, S_NABS, S_NSHIFT, S_SQSET, S_SQACC, S_SQRT, S_DINIT, S_DIV, S_NDONE,
    S_D1SET, S_D1ACC, S_DIFF, S_DIFFACC, S_SPECCHK, S_RSET, S_RACC, S_D2SET, S_D2ACC,
    S_PCHK, S_PSET, S_PMUL, S_PSQ, S_PSQMUL, S_SPEC, S_SPECACC, S_SHAD, S_SHADACC,
    S_ACCUM
  } state_t;

  state_t state;

  // Stored set-up.
  logic signed [31:0]   hit [3];
  logic signed [UW-1:0] nrm [3];
  logic signed [UW-1:0] vw  [3];
  logic [EXP_BITS-1:0]  spec_exp;
  logic [31:0]          sum;

  // Latched light transfer.
  logic [1:0]  cmode;
  logic [31:0] level;
  logic        shd;
  logic [16:0] clar;
  logic        last;

  // Normalization working registers.
  logic signed [32:0]   vin  [3];
  logic [32:0]          mag  [3];
  logic [32:0]          top;
  logic [63:0]          sq;
  logic [63:0]          sx;
  logic [63:0]          sr;
  logic [63:0]          sb;
  logic [31:0]          len;
  logic [32:0]          rem;
  logic [FRAC_BITS:0]   quo;
  logic signed [UW-1:0] uvec [3];
  logic signed [UW-1:0] lu   [3];
  logic [1:0]           idx;
  logic [CNT_W-1:0]     cnt;

  // Shading working registers.
  logic signed [MW-1:0] ma;
  logic signed [MW-1:0] mb;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] dnl;
  logic signed [AW-1:0] sv;
  logic signed [RW-1:0] rv [3];
  logic [FRAC_BITS:0]   pacc;
  logic [FRAC_BITS:0]   pbase;
  logic [EXP_BITS-1:0]  pe;
  logic [CTW-1:0]       contrib;

  // The shared multiplier, fed from registered operands.
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_f;
  logic signed [PW-1:0] prod_16;
  assign prod    = ma * mb;
  assign prod_f  = prod >>> FRAC_BITS;
  assign prod_16 = prod >>> 16;

  // Division by 2^F that truncates toward zero, as the fixed-point format requires.
  function automatic logic signed [AW-1:0] tdiv(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] bias;
    bias = x[AW-1] ? AW'((64'd1 << FRAC_BITS) - 64'd1) : '0;
    return (x + bias) >>> FRAC_BITS;
  endfunction

  assign in_ready = (state == S_IDLE);

  logic signed [32:0] in_v [3];
  assign in_v[0] = 33'(vec_x);
  assign in_v[1] = 33'(vec_y);
  assign in_v[2] = 33'(vec_z);

  // Magnitudes and their largest, for the first normalization step.
  logic [32:0] abs_v [3];
  logic [32:0] abs_max;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = vin[i][32] ? 33'(-vin[i]) : 33'(vin[i]);
    end
    abs_max = abs_v[0];
    if (abs_v[1] > abs_max) abs_max = abs_v[1];
    if (abs_v[2] > abs_max) abs_max = abs_v[2];
  end

  // One step of the bitwise square root.
  logic [63:0] sq_t;
  logic        sq_ge;
  logic [63:0] sx_next;
  logic [63:0] sr_next;
  always_comb begin
    sq_t    = sr + sb;
    sq_ge   = (sx >= sq_t);
    sx_next = sq_ge ? sx - sq_t : sx;
    sr_next = sq_ge ? (sr >> 1) + sb : sr >> 1;
  end

  // One step of the restoring divider.
  logic               dv_ge;
  logic [32:0]        dv_sub;
  logic [32:0]        rem_next;
  logic [FRAC_BITS:0] quo_next;
  always_comb begin
    dv_ge    = (rem >= {1'b0, len});
    dv_sub   = dv_ge ? rem - {1'b0, len} : rem;
    rem_next = {dv_sub[31:0], 1'b0};
    quo_next = {quo[FRAC_BITS-1:0], dv_ge};
  end

  logic signed [AW-1:0] acc_sum;
  logic signed [AW-1:0] r_trunc;
  assign acc_sum = acc + prod[AW-1:0];
  assign r_trunc = tdiv(prod[AW-1:0]);

  logic [FRAC_BITS:0] cd;
  logic [FRAC_BITS:0] cs;
  assign cd = (dnl > AW'(ONE)) ? ONE : dnl[FRAC_BITS:0];
  assign cs = (sv > AW'(ONE)) ? ONE : sv[FRAC_BITS:0];

  logic [31:0] exp_raw;
  assign exp_raw = scalar >> FRAC_BITS;

  logic [33:0] sum_wide;
  logic [31:0] sum_sat;
  assign sum_wide = {2'b00, sum} + {1'b0, contrib};
  assign sum_sat  = (sum_wide[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum_wide[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_valid <= 1'b0;
      sum      <= '0;
      spec_exp <= '0;
      for (int i = 0; i < 3; i++) begin
        hit[i] <= '0;
        nrm[i] <= '0;
        vw[i]  <= '0;
      end
    end else begin
      // A last light that posts a new sum in this cycle sets out_valid itself.
      if (out_valid && out_ready && !(state == S_ACCUM && last)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmode   <= mode;
            level   <= scalar;
            shd     <= in_shadow;
            clar    <= (occluder_clarity > CLARITY_ONE) ? CLARITY_ONE : occluder_clarity;
            last    <= last_light;
            contrib <= (mode == MODE_LIGHT && light_kind == KIND_AMBIENT) ?
                       {1'b0, scalar} : '0;
            case (mode)
              MODE_HIT: begin
                hit[0] <= vec_x;
                hit[1] <= vec_y;
                hit[2] <= vec_z;
              end
              MODE_NORMAL: begin
                for (int i = 0; i < 3; i++) vin[i] <= in_v[i];
                state <= S_NABS;
              end
              MODE_VIEW: begin
                for (int i = 0; i < 3; i++) vin[i] <= in_v[i];
                spec_exp <= (exp_raw > 32'(EXP_MAX)) ? EXP_MAX : exp_raw[EXP_BITS-1:0];
                state <= S_NABS;
              end
              default: begin
                case (light_kind)
                  KIND_POINT: begin
                    for (int i = 0; i < 3; i++) vin[i] <= in_v[i] - 33'(hit[i]);
                    state <= S_NABS;
                  end
                  KIND_DIRECTIONAL: begin
                    for (int i = 0; i < 3; i++) vin[i] <= in_v[i];
                    state <= S_NABS;
                  end
                  default: begin
                    state <= S_ACCUM;
                  end
                endcase
              end
            endcase
          end
        end
        S_NABS: begin
          for (int i = 0; i < 3; i++) mag[i] <= abs_v[i];
          top <= abs_max;
          sq  <= '0;
          idx <= '0;
          if (abs_max == '0) begin
            for (int i = 0; i < 3; i++) uvec[i] <= '0;
            state <= S_NDONE;
          end else begin
            state <= S_NSHIFT;
          end
        end
        S_NSHIFT: begin
          if (top >= 33'h0_8000_0000) begin
            top <= top >> 1;
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (top < 33'h0_4000_0000) begin
            top <= top << 1;
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            state <= S_SQSET;
          end
        end
        S_SQSET: begin
          ma    <= MW'(mag[idx]);
          mb    <= MW'(mag[idx]);
          state <= S_SQACC;
        end
        S_SQACC: begin
          sq <= sq + prod[63:0];
          if (idx == 2'd2) begin
            sx    <= sq + prod[63:0];
            sr    <= '0;
            sb    <= 64'd1 << 62;
            cnt   <= CNT_W'(31);
            idx   <= '0;
            state <= S_SQRT;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_SQSET;
          end
        end
        S_SQRT: begin
          sx  <= sx_next;
          sr  <= sr_next;
          sb  <= sb >> 2;
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            len   <= sr_next[31:0];
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          rem   <= mag[idx];
          quo   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(FRAC_BITS)) begin
            uvec[idx] <= vin[idx][32] ? -UW'({1'b0, quo_next}) : UW'({1'b0, quo_next});
            if (idx == 2'd2) begin
              idx   <= '0;
              state <= S_NDONE;
            end else begin
              idx   <= idx + 2'd1;
              state <= S_DINIT;
            end
          end
        end
        S_NDONE: begin
          idx <= '0;
          acc <= '0;
          case (cmode)
            MODE_NORMAL: begin
              for (int i = 0; i < 3; i++) nrm[i] <= uvec[i];
              state <= S_IDLE;
            end
            MODE_VIEW: begin
              for (int i = 0; i < 3; i++) vw[i] <= uvec[i];
              state <= S_IDLE;
            end
            default: begin
              for (int i = 0; i < 3; i++) lu[i] <= uvec[i];
              state <= S_D1SET;
            end
          endcase
        end
        S_D1SET: begin
          ma    <= MW'(nrm[idx]);
          mb    <= MW'(lu[idx]);
          state <= S_D1ACC;
        end
        S_D1ACC: begin
          acc <= acc_sum;
          if (idx == 2'd2) begin
            dnl   <= tdiv(acc_sum);
            idx   <= '0;
            state <= S_DIFF;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_D1SET;
          end
        end
        S_DIFF: begin
          // Only a light in front of the surface lights it diffusely.
          if (!dnl[AW-1] && dnl != '0) begin
            ma    <= MW'(level);
            mb    <= MW'(cd);
            state <= S_DIFFACC;
          end else begin
            state <= S_SPECCHK;
          end
        end
        S_DIFFACC: begin
          contrib <= CTW'(prod_f[31:0]);
          state   <= S_SPECCHK;
        end
        S_SPECCHK: begin
          idx <= '0;
          acc <= '0;
          state <= (spec_exp != '0) ? S_RSET : S_SHAD;
        end
        S_RSET: begin
          ma    <= MW'(nrm[idx]);
          mb    <= MW'(dnl);
          state <= S_RACC;
        end
        S_RACC: begin
          rv[idx] <= RW'((r_trunc <<< 1) - AW'(lu[idx]));
          if (idx == 2'd2) begin
            idx   <= '0;
            state <= S_D2SET;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_RSET;
          end
        end
        S_D2SET: begin
          ma    <= MW'(rv[idx]);
          mb    <= MW'(vw[idx]);
          state <= S_D2ACC;
        end
        S_D2ACC: begin
          acc <= acc_sum;
          if (idx == 2'd2) begin
            sv    <= tdiv(acc_sum);
            idx   <= '0;
            state <= S_PCHK;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_D2SET;
          end
        end
        S_PCHK: begin
          pacc  <= ONE;
          pbase <= cs;
          pe    <= spec_exp;
          state <= (!sv[AW-1] && sv != '0) ? S_PSET : S_SHAD;
        end
        S_PSET: begin
          if (pe[0]) begin
            ma    <= MW'(pacc);
            mb    <= MW'(pbase);
            state <= S_PMUL;
          end else begin
            state <= S_PSQ;
          end
        end
        S_PMUL: begin
          pacc  <= prod_f[FRAC_BITS:0];
          state <= S_PSQ;
        end
        S_PSQ: begin
          ma    <= MW'(pbase);
          mb    <= MW'(pbase);
          state <= S_PSQMUL;
        end
        S_PSQMUL: begin
          pbase <= prod_f[FRAC_BITS:0];
          pe    <= pe >> 1;
          state <= (pe[EXP_BITS-1:1] == '0) ? S_SPEC : S_PSET;
        end
        S_SPEC: begin
          ma    <= MW'(level);
          mb    <= MW'(pacc);
          state <= S_SPECACC;
        end
        S_SPECACC: begin
          contrib <= contrib + CTW'(prod_f[31:0]);
          state   <= S_SHAD;
        end
        S_SHAD: begin
          if (shd) begin
            ma    <= MW'(contrib);
            mb    <= MW'(clar);
            state <= S_SHADACC;
          end else begin
            state <= S_ACCUM;
          end
        end
        S_SHADACC: begin
          contrib <= prod_16[CTW-1:0];
          state   <= S_ACCUM;
        end
        S_ACCUM: begin
          // A last light waits here while the previous sum is still uncollected.
          if (!(last && out_valid && !out_ready)) begin
            if (last) begin
              total_intensity <= sum_sat;
              out_valid       <= 1'b1;
              sum             <= '0;
            end else begin
              sum <= sum_sat;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> dv/phong_light_accumulator_unit_tb.sv
module phong_light_accumulator_unit_tb;
  import pla_pkg::*;

  typedef longint vec3_t [3];

  // One input transfer as the sender presents it.
  typedef struct {
    mode_t              mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [31:0]        scalar;
    kind_t              kind;
    logic               shadow;
    logic [16:0]        clarity;
    logic               last;
  } light_item_t;

  // Scoreboard: keeps its own copy of the hit point, normal, view and sum, predicts the
  // intensity that each closing light produces and checks the block's results in order.
  class intensity_scoreboard;
    vec3_t            hit;
    vec3_t            normal;
    vec3_t            view;
    int unsigned      exponent;
    longint unsigned  sum;
    logic [31:0]      intensity_q[$];
    int               mismatches;

    function new();
      hit = '{0, 0, 0};
      normal = '{0, 0, 0};
      view = '{0, 0, 0};
      exponent = 0;
      sum = 0;
      mismatches = 0;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic void to_unit(input vec3_t v, output vec3_t u);
      longint unsigned mag[3];
      longint unsigned top, sq, len;
      longint q;
      top = 0;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = v[i] < 0 ? -v[i] : v[i];
        if (mag[i] > top) top = mag[i];
      end
      u = '{0, 0, 0};
      if (top == 0) return;
      while (top >= (64'd1 << 31)) begin
        top >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (top < (64'd1 << 30)) begin
        top <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sq += mag[i] * mag[i];
      len = isqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q = longint'((mag[i] << FRAC_BITS) / len);
        u[i] = v[i] < 0 ? -q : q;
      end
    endfunction

    function automatic longint dot(input vec3_t a, input vec3_t b);
      return (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) / (longint'(1) <<< FRAC_BITS);
    endfunction

    function automatic longint unsigned raise(longint unsigned base, int unsigned e);
      longint unsigned acc;
      acc = 64'd1 << FRAC_BITS;
      while (e != 0) begin
        if (e[0]) acc = (acc * base) >> FRAC_BITS;
        base = (base * base) >> FRAC_BITS;
        e >>= 1;
      end
      return acc;
    endfunction

    // Called for every accepted input transfer.
    function automatic void note_input(light_item_t it);
      vec3_t v, lv, l, n, w, r;
      longint dnl, sv;
      longint unsigned level, add, contrib, cd, cs, clar, e;
      v = '{it.x, it.y, it.z};
      level = it.scalar;
      add = 0;
      case (it.mode)
        MODE_HIT: begin
          hit = v;
          return;
        end
        MODE_NORMAL: begin
          normal = v;
          return;
        end
        MODE_VIEW: begin
          view = v;
          e = level >> FRAC_BITS;
          exponent = e > EXP_MAX ? EXP_MAX : e;
          return;
        end
        default: ;
      endcase
      if (it.kind == KIND_AMBIENT) begin
        add = level;
      end else if (it.kind == KIND_POINT || it.kind == KIND_DIRECTIONAL) begin
        contrib = 0;
        for (int i = 0; i < 3; i++) lv[i] = it.kind == KIND_POINT ? v[i] - hit[i] : v[i];
        to_unit(lv, l);
        to_unit(normal, n);
        to_unit(view, w);
        dnl = dot(n, l);
        if (dnl > 0) begin
          cd = dnl > ONE ? ONE : dnl;
          contrib += (level * cd) >> FRAC_BITS;
        end
        if (exponent > 0) begin
          for (int i = 0; i < 3; i++)
            r[i] = 2 * ((n[i] * dnl) / (longint'(1) <<< FRAC_BITS)) - l[i];
          sv = dot(r, w);
          if (sv > 0) begin
            cs = sv > ONE ? ONE : sv;
            contrib += (level * raise(cs, exponent)) >> FRAC_BITS;
          end
        end
        if (it.shadow) begin
          clar = it.clarity > CLARITY_ONE ? CLARITY_ONE : it.clarity;
          contrib = (contrib * clar) >> 16;
        end
        add = contrib;
      end
      sum = sum + add;
      if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
      if (it.last) begin
        intensity_q.push_back(sum[31:0]);
        sum = 0;
      end
    endfunction

    // Called for every accepted result transfer.
    function automatic void check_result(logic [31:0] got);
      logic [31:0] want;
      if (intensity_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: total_intensity %h", got);
        return;
      end
      want = intensity_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("total_intensity mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         mode;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic [31:0]        scalar;
  logic [1:0]         light_kind;
  logic               in_shadow;
  logic [16:0]        occluder_clarity;
  logic               last_light;
  logic               out_valid;
  logic               out_ready;
  logic [31:0]        total_intensity;

  intensity_scoreboard sb = new();
  // Set for the closing part of the run, in which neither side idles.
  bit                  calm = 0;

  phong_light_accumulator_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .mode             (mode),
    .vec_x            (vec_x),
    .vec_y            (vec_y),
    .vec_z            (vec_z),
    .scalar           (scalar),
    .light_kind       (light_kind),
    .in_shadow        (in_shadow),
    .occluder_clarity (occluder_clarity),
    .last_light       (last_light),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .total_intensity  (total_intensity)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Both channels are observed at the rising edge. The drivers update with nonblocking
  // assignments, so the values seen here are those that took part in the transfer.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_input('{mode_t'(mode), vec_x, vec_y, vec_z, scalar, kind_t'(light_kind),
                      in_shadow, occluder_clarity, last_light});
    if (!rst && out_valid && out_ready)
      sb.check_result(total_intensity);
  end

  // The receiver stalls in random bursts, except in the calm part.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Presents one item and returns at the edge that transfers it, or after an idle burst.
  // in_ready is looked at on the falling edge, where it is settled.
  task automatic send(light_item_t it);
    in_valid         <= 1'b1;
    mode             <= it.mode;
    vec_x            <= it.x;
    vec_y            <= it.y;
    vec_z            <= it.z;
    scalar           <= it.scalar;
    light_kind       <= it.kind;
    in_shadow        <= it.shadow;
    occluder_clarity <= it.clarity;
    last_light       <= it.last;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    // A random burst of idle cycles between transfers.
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  function automatic light_item_t make(mode_t m, int x, int y, int z, int unsigned s,
                                       kind_t k, bit sh, int unsigned cl, bit last);
    light_item_t it;
    it.mode = m;
    it.x = x;
    it.y = y;
    it.z = z;
    it.scalar = s;
    it.kind = k;
    it.shadow = sh;
    it.clarity = 17'(cl);
    it.last = last;
    return it;
  endfunction

  // A vector component: mostly a few units either way, sometimes any 32-bit value.
  function automatic int comp();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
  endfunction

  function automatic light_item_t random_light(bit last);
    light_item_t it;
    int unsigned level;
    level = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0004_0000);
    it = make(MODE_LIGHT, comp(), comp(), comp(), level,
              kind_t'($urandom_range(0, 9) == 0 ? KIND_UNUSED : $urandom_range(0, 2)),
              $urandom_range(0, 1), $urandom_range(0, 1) ? $urandom_range(0, 17'h1FFFF)
                                                        : $urandom_range(0, 17'h10000),
              last);
    return it;
  endfunction

  // A set-up sequence for one hit point followed by its lights, the last one closing it.
  task automatic hit_sequence();
    int nlights;
    int unsigned ex;
    nlights = $urandom_range(1, 5);
    ex = $urandom_range(0, 7) == 0 ? $urandom() : ($urandom_range(0, 40) << FRAC_BITS)
         | $urandom_range(0, 16'hFFFF);
    send(make(MODE_HIT, comp(), comp(), comp(), $urandom(), KIND_AMBIENT, $urandom_range(0, 1),
              $urandom_range(0, 17'h1FFFF), $urandom_range(0, 1)));
    send(make(MODE_NORMAL, comp(), comp(), comp(), $urandom(), KIND_POINT, 0, 0,
              $urandom_range(0, 1)));
    send(make(MODE_VIEW, comp(), comp(), comp(), ex, KIND_DIRECTIONAL, 0, 0,
              $urandom_range(0, 1)));
    for (int i = 0; i < nlights; i++) send(random_light(i == nlights - 1));
  endtask

  initial begin
    int sent;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_HIT;
    vec_x = '0;
    vec_y = '0;
    vec_z = '0;
    scalar = '0;
    light_kind = KIND_AMBIENT;
    in_shadow = 1'b0;
    occluder_clarity = '0;
    last_light = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A point light against the zero vectors left by reset adds nothing.
    send(make(MODE_LIGHT, 32'sh0001_0000, 0, 0, 32'h0001_0000, KIND_POINT, 0, 0, 0));
    send(make(MODE_LIGHT, 0, 0, 0, 32'h0002_0000, KIND_AMBIENT, 1, 0, 1));
    // A normal along z, a view in the y-z plane and a large exponent that saturates.
    send(make(MODE_HIT, 32'sh0001_0000, -32'sh0002_0000, 0, 0, KIND_AMBIENT, 0, 0, 1));
    send(make(MODE_NORMAL, 0, 0, 32'sh0001_0000, 0, KIND_AMBIENT, 0, 0, 1));
    send(make(MODE_VIEW, 0, 32'sh0000_8000, 32'sh0001_0000, 32'hFFFF_FFFF, KIND_AMBIENT, 0, 0, 0));
    send(make(MODE_LIGHT, 0, 0, 32'sh0003_0000, 32'h0001_0000, KIND_DIRECTIONAL, 0, 0, 0));
    send(make(MODE_LIGHT, 32'sh0001_0000, -32'sh0002_0000, 32'sh0005_0000, 32'h0001_8000,
              KIND_POINT, 1, 17'h08000, 0));
    // An opaque occluder, a clarity above one and the unused light kind.
    send(make(MODE_LIGHT, 0, 0, 32'sh0001_0000, 32'h0010_0000, KIND_DIRECTIONAL, 1, 0, 0));
    send(make(MODE_LIGHT, 0, 0, 32'sh0001_0000, 32'h0001_0000, KIND_DIRECTIONAL, 1, 17'h1FFFF, 0));
    send(make(MODE_LIGHT, 0, 0, 32'sh0001_0000, 32'h0001_0000, KIND_UNUSED, 0, 0, 1));
    send(make(MODE_LIGHT, 0, 0, 0, 32'h0000_0000, KIND_UNUSED, 0, 0, 1));
    // Field extremes; the full-scale levels drive the sum into saturation.
    send(make(MODE_VIEW, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000,
              KIND_AMBIENT, 0, 0, 0));
    send(make(MODE_NORMAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, KIND_AMBIENT, 0, 0, 0));
    send(make(MODE_HIT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, KIND_AMBIENT, 0, 0, 0));
    send(make(MODE_LIGHT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              KIND_POINT, 0, 0, 0));
    send(make(MODE_LIGHT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
              KIND_DIRECTIONAL, 1, 17'h10000, 0));
    send(make(MODE_LIGHT, 0, 0, 0, 32'hFFFF_FFFF, KIND_AMBIENT, 0, 0, 1));
    send(make(MODE_VIEW, 0, 0, 0, 32'h0003_0000, KIND_AMBIENT, 0, 0, 0));
    send(make(MODE_LIGHT, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'h0002_0000,
              KIND_DIRECTIONAL, 0, 0, 1));
    sent = 19;

    // Hold the sender back until every expected intensity has been collected. The falling
    // edge lets the scoreboard note the transfer of the same rising edge first.
    in_valid <= 1'b0;
    @(negedge clk);
    wait (sb.intensity_q.size() == 0);
    @(posedge clk);

    // Random part: mostly complete hit point sequences, with some stray transfers.
    while (sent < 650) begin
      if (sent > 560) calm = 1;
      if ($urandom_range(0, 5) == 0) begin
        send($urandom_range(0, 1) ? random_light($urandom_range(0, 1))
             : make(mode_t'($urandom_range(0, 2)), comp(), comp(), comp(), $urandom(),
                    kind_t'($urandom_range(0, 3)), 0, 0, $urandom_range(0, 1)));
        sent++;
      end else begin
        hit_sequence();
        sent += 6;
      end
    end
    in_valid <= 1'b0;

    @(negedge clk);
    wait (sb.intensity_q.size() == 0);
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.intensity_q.size() == 0) begin
      $display("phong_light_accumulator_unit_tb OK");
    end else begin
      $display("phong_light_accumulator_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("phong_light_accumulator_unit_tb NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
rtl/pla_pkg.sv
rtl/phong_light_accumulator_unit.sv
dv/phong_light_accumulator_unit_tb.sv
